// ===== rtl/pidaw_pkg.sv =====
`timescale 1ns / 1ps
// Package for the PID controller with integral anti-windup.
// Holds field widths, derived datapath widths, saturation bounds and register indexes.
// No dependencies.
package pidaw_pkg;

  // Field and register widths.
  localparam int SAMPLE_WIDTH = 16;
  localparam int FRAC_BITS    = 8;
  localparam int SETPOINT_W   = 16;
  localparam int GAIN_W       = 16;
  localparam int TIME_W       = 32;
  localparam int LIMIT_W      = 47;
  localparam int INTEG_W      = 48;
  localparam int DERIV_W      = 32;
  localparam int DRIVE_W      = 32;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = LIMIT_W;

  // Error and its magnitude.
  localparam int ERR_W = ((SAMPLE_WIDTH > SETPOINT_W) ? SAMPLE_WIDTH : SETPOINT_W) + 1;
  localparam int MAG_W = ERR_W - 1;

  // Integral path: |error| * dt, limited to 2^PROD_LIM_W, then a signed accumulate.
  localparam int PROD_W     = MAG_W + TIME_W;
  localparam int PROD_LIM_W = 48;
  localparam int PCMP_W     = (PROD_W > PROD_LIM_W) ? PROD_W + 1 : PROD_LIM_W + 1;
  localparam int ACC_W      = INTEG_W + 2;
  localparam logic [PCMP_W-1:0] PROD_LIM = PCMP_W'(1) << PROD_LIM_W;

  // Derivative path: (error change << FRAC_BITS) / dt, magnitude divide.
  localparam int DIFF_W = ERR_W + 1;
  localparam int QMAG_W = DIFF_W - 1 + FRAC_BITS;
  localparam int CMP_W  = ((QMAG_W > DERIV_W) ? QMAG_W : DERIV_W) + 1;
  localparam logic [CMP_W-1:0] DERIV_POS     = (CMP_W'(1) << (DERIV_W - 1)) - CMP_W'(1);
  localparam logic [CMP_W-1:0] DERIV_NEG_MAG = CMP_W'(1) << (DERIV_W - 1);

  // Output sum of the three gain products.
  localparam int PTERM_W = GAIN_W + ERR_W;
  localparam int ITERM_W = GAIN_W + INTEG_W;
  localparam int DTERM_W = GAIN_W + DERIV_W;
  localparam int SUM_W   = ITERM_W + 2;
  localparam logic signed [SUM_W-1:0] DRIVE_HI =
    $signed((SUM_W'(1) << (DRIVE_W - 1)) - SUM_W'(1));
  localparam logic signed [SUM_W-1:0] DRIVE_LO = ~DRIVE_HI;

  // Sequencing counts.
  localparam int RUN1_STEPS = (QMAG_W > MAG_W) ? QMAG_W : MAG_W;
  localparam int CNT_MAX    = (RUN1_STEPS > GAIN_W) ? RUN1_STEPS : GAIN_W;
  localparam int CNT_W      = $clog2(CNT_MAX + 1);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SETPOINT      = 3'd0,
    REG_GAIN_P        = 3'd1,
    REG_GAIN_I        = 3'd2,
    REG_GAIN_D        = 3'd3,
    REG_SAMPLE_PERIOD = 3'd4,
    REG_WINDUP_LIMIT  = 3'd5
  } cfg_reg_t;

endpackage

// ===== rtl/pid_controller_anti_windup_core.sv =====
`timescale 1ns / 1ps
// PID controller with integral anti-windup, top level.
// Depends on pidaw_pkg for widths, bounds and register indexes.
//
// Each input transaction carries a feedback sample and a millisecond timestamp and yields
// exactly one output transaction. When the time since the last taken sample reaches
// sample_period, the sample is taken: the integral gains error*dt and is clamped to
// +-windup_limit, the derivative becomes (error change << 8) / dt (kept when dt is zero),
// and drive is recomputed from the Q8.8 gains and saturated to 32 bits; otherwise the held
// drive is returned with sampled low. The block works on one transaction at a time. A taken
// sample occupies it from acceptance to the next acceptance: a bit-serial multiplier forms
// |error|*dt while a restoring divider retires one quotient bit per cycle; then the integral
// is clamped, three shift-add multipliers walk the gain bits, and the sum is saturated and
// loaded into the output register. A sample below the period gate goes straight to the
// emit step. The output register holds a finished result while the block already accepts
// the next transaction; input stall is high whenever the sequencer is busy. The user must
// write configuration only while the block is idle; the block itself does not enforce it.
module pid_controller_anti_windup_core (
  input  logic                                      clk,
  input  logic                                      rst,
  // Configuration write port.
  input  logic                                      wr_en,
  input  logic [pidaw_pkg::CFG_IDX_W-1:0]           wr_index,
  input  logic [pidaw_pkg::CFG_DATA_W-1:0]          wr_data,
  // Input channel.
  input  logic                                      in_valid,
  output logic                                      in_stall,
  input  logic signed [pidaw_pkg::SAMPLE_WIDTH-1:0] feedback,
  input  logic [pidaw_pkg::TIME_W-1:0]              now_ms,
  // Output channel.
  output logic                                      out_valid,
  input  logic                                      out_stall,
  output logic signed [pidaw_pkg::DRIVE_W-1:0]      drive,
  output logic                                      sampled
);
  import pidaw_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN1,
    ST_INTEG,
    ST_RUN2,
    ST_SUM,
    ST_SAT,
    ST_EMIT
  } state_t;

  state_t state;

  // Configuration registers.
  logic signed [SETPOINT_W-1:0] setpoint;
  logic signed [GAIN_W-1:0]     gain_p;
  logic signed [GAIN_W-1:0]     gain_i;
  logic signed [GAIN_W-1:0]     gain_d;
  logic [TIME_W-1:0]            sample_period;
  logic [LIMIT_W-1:0]           windup_limit;

  // Controller state.
  logic [TIME_W-1:0]          prev_time;
  logic signed [ERR_W-1:0]    prev_error;
  logic signed [INTEG_W-1:0]  integral;
  logic signed [DERIV_W-1:0]  derivative;
  logic signed [DRIVE_W-1:0]  held_drive;

  // Per-transaction working registers.
  logic signed [ERR_W-1:0] err_r;
  logic                    err_neg_r;
  logic [TIME_W-1:0]       dt_r;
  logic [TIME_W-1:0]       now_r;
  logic                    taken_r;
  logic [CNT_W-1:0]        cnt;

  // Bit-serial |error| * dt.
  logic [MAG_W-1:0]  pm_mult;
  logic [PROD_W-1:0] pm_mcand;
  logic [PROD_W-1:0] pm_acc;

  // Restoring divider: the dividend register fills with quotient bits.
  logic [QMAG_W-1:0] div_dvd;
  logic [TIME_W-1:0] div_rem;
  logic              div_neg;

  // Gain multipliers, one gain bit per cycle.
  logic [GAIN_W-1:0]         gp_m, gi_m, gd_m;
  logic signed [PTERM_W-1:0] p_mc, p_acc;
  logic signed [ITERM_W-1:0] i_mc, i_acc;
  logic signed [DTERM_W-1:0] d_mc, d_acc;
  logic signed [SUM_W-1:0]   sum;

  // Accept-time values.
  logic                    in_take;
  logic signed [ERR_W-1:0] err_in;
  logic [TIME_W-1:0]       dt_in;
  logic                    gate_in;
  logic signed [DIFF_W-1:0] diff_in;
  logic [DIFF_W-1:0]       diff_mag;

  assign in_stall = (state != ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign err_in   = ERR_W'(setpoint) - ERR_W'(feedback);
  assign dt_in    = now_ms - prev_time;
  assign gate_in  = (dt_in >= sample_period);
  assign diff_in  = DIFF_W'(err_in) - DIFF_W'(prev_error);
  assign diff_mag = diff_in[DIFF_W-1] ? DIFF_W'(-diff_in) : DIFF_W'(diff_in);

  // One restoring divide step.
  logic [TIME_W:0]   rem_sh;
  logic              q_bit;
  logic [TIME_W-1:0] rem_next;

  always_comb begin
    rem_sh = {div_rem, div_dvd[QMAG_W-1]};
    q_bit  = (rem_sh >= {1'b0, dt_r});
    if (q_bit) begin
      rem_next = TIME_W'(rem_sh - {1'b0, dt_r});
    end else begin
      rem_next = TIME_W'(rem_sh);
    end
  end

  // Integral update with the windup clamp.
  logic [PCMP_W-1:0]        prod_wide, prod_sat;
  logic signed [ACC_W-1:0]  prod_pos, prod_signed, acc_sum, lim_pos, lim_neg, acc_clamp;
  logic signed [INTEG_W-1:0] integral_next;

  always_comb begin
    prod_wide   = PCMP_W'(pm_acc);
    prod_sat    = (prod_wide > PROD_LIM) ? PROD_LIM : prod_wide;
    prod_pos    = $signed(ACC_W'(prod_sat));
    prod_signed = err_neg_r ? -prod_pos : prod_pos;
    acc_sum     = ACC_W'(integral) + prod_signed;
    lim_pos     = $signed(ACC_W'(windup_limit));
    lim_neg     = -lim_pos;
    if (acc_sum > lim_pos) begin
      acc_clamp = lim_pos;
    end else if (acc_sum < lim_neg) begin
      acc_clamp = lim_neg;
    end else begin
      acc_clamp = acc_sum;
    end
    integral_next = INTEG_W'(acc_clamp);
  end

  // Derivative from the quotient magnitude, truncated toward zero and saturated.
  logic [CMP_W-1:0]          q_wide;
  logic signed [DERIV_W-1:0] derivative_next;

  always_comb begin
    q_wide = CMP_W'(div_dvd);
    if (dt_r == '0) begin
      derivative_next = derivative;
    end else if (!div_neg) begin
      derivative_next = (q_wide > DERIV_POS) ? DERIV_W'(DERIV_POS) : DERIV_W'(q_wide);
    end else begin
      derivative_next = (q_wide > DERIV_NEG_MAG) ? DERIV_W'(DERIV_NEG_MAG) : DERIV_W'(-q_wide);
    end
  end

  // The top gain bit carries negative weight.
  logic sign_step;
  assign sign_step = (cnt == CNT_W'(GAIN_W - 1));

  // Final scaling and output saturation.
  logic signed [SUM_W-1:0] sum_sh;
  assign sum_sh = sum >>> FRAC_BITS;

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint      <= '0;
      gain_p        <= '0;
      gain_i        <= '0;
      gain_d        <= '0;
      sample_period <= '0;
      windup_limit  <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_SETPOINT:      setpoint      <= wr_data[SETPOINT_W-1:0];
        REG_GAIN_P:        gain_p        <= wr_data[GAIN_W-1:0];
        REG_GAIN_I:        gain_i        <= wr_data[GAIN_W-1:0];
        REG_GAIN_D:        gain_d        <= wr_data[GAIN_W-1:0];
        REG_SAMPLE_PERIOD: sample_period <= wr_data[TIME_W-1:0];
        REG_WINDUP_LIMIT:  windup_limit  <= wr_data[LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Controller state commits at the integral step and at saturation.
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_time  <= '0;
      prev_error <= '0;
      integral   <= '0;
      derivative <= '0;
      held_drive <= '0;
    end else if (state == ST_INTEG) begin
      prev_time  <= now_r;
      prev_error <= err_r;
      integral   <= integral_next;
      derivative <= derivative_next;
    end else if (state == ST_SAT) begin
      if (sum_sh > DRIVE_HI) begin
        held_drive <= DRIVE_W'(DRIVE_HI);
      end else if (sum_sh < DRIVE_LO) begin
        held_drive <= DRIVE_W'(DRIVE_LO);
      end else begin
        held_drive <= DRIVE_W'(sum_sh);
      end
    end
  end

  // Datapath work registers.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_take) begin
          err_r     <= err_in;
          err_neg_r <= err_in[ERR_W-1];
          dt_r      <= dt_in;
          now_r     <= now_ms;
          taken_r   <= gate_in;
          cnt       <= '0;
          pm_mult   <= err_in[ERR_W-1] ? MAG_W'(-err_in) : MAG_W'(err_in);
          pm_mcand  <= PROD_W'(dt_in);
          pm_acc    <= '0;
          div_dvd   <= QMAG_W'(diff_mag) << FRAC_BITS;
          div_rem   <= '0;
          div_neg   <= diff_in[DIFF_W-1];
        end
      end
      ST_RUN1: begin
        if (cnt < CNT_W'(MAG_W)) begin
          if (pm_mult[0]) begin
            pm_acc <= pm_acc + pm_mcand;
          end
          pm_mcand <= pm_mcand << 1;
          pm_mult  <= pm_mult >> 1;
        end
        if (cnt < CNT_W'(QMAG_W)) begin
          div_rem <= rem_next;
          div_dvd <= {div_dvd[QMAG_W-2:0], q_bit};
        end
        cnt <= cnt + CNT_W'(1);
      end
      ST_INTEG: begin
        cnt   <= '0;
        gp_m  <= gain_p;
        gi_m  <= gain_i;
        gd_m  <= gain_d;
        p_mc  <= PTERM_W'(err_r);
        i_mc  <= ITERM_W'(integral_next);
        d_mc  <= DTERM_W'(derivative_next);
        p_acc <= '0;
        i_acc <= '0;
        d_acc <= '0;
      end
      ST_RUN2: begin
        if (gp_m[0]) begin
          p_acc <= sign_step ? p_acc - p_mc : p_acc + p_mc;
        end
        if (gi_m[0]) begin
          i_acc <= sign_step ? i_acc - i_mc : i_acc + i_mc;
        end
        if (gd_m[0]) begin
          d_acc <= sign_step ? d_acc - d_mc : d_acc + d_mc;
        end
        p_mc <= p_mc << 1;
        i_mc <= i_mc << 1;
        d_mc <= d_mc << 1;
        gp_m <= gp_m >> 1;
        gi_m <= gi_m >> 1;
        gd_m <= gd_m >> 1;
        cnt  <= cnt + CNT_W'(1);
      end
      ST_SUM: begin
        sum <= SUM_W'(p_acc) + SUM_W'(i_acc) + SUM_W'(d_acc >>> FRAC_BITS);
      end
      default: begin
      end
    endcase
  end

  // Sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      // The emit step loads the output register once the previous result has left.
      if (state == ST_EMIT && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
        drive     <= held_drive;
        sampled   <= taken_r;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_take) begin
            state <= gate_in ? ST_RUN1 : ST_EMIT;
          end
        end
        ST_RUN1: begin
          if (cnt == CNT_W'(RUN1_STEPS - 1)) begin
            state <= ST_INTEG;
          end
        end
        ST_INTEG: begin
          state <= ST_RUN2;
        end
        ST_RUN2: begin
          if (sign_step) begin
            state <= ST_SUM;
          end
        end
        ST_SUM: begin
          state <= ST_SAT;
        end
        ST_SAT: begin
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (!out_valid || !out_stall) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // The divider remainder stays below a nonzero divisor throughout the divide.
  a_div_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN1 && dt_r != '0) |-> (div_rem < dt_r))
    else $error("divider remainder not below divisor");

  // A new output transaction only appears after the emit step.
  a_out_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_EMIT))
    else $error("output loaded outside the emit step");

  // A taken sample has committed its timestamp before its result is loaded.
  a_time_committed: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && taken_r) |-> (prev_time == now_r))
    else $error("sample emitted before its time was stored");
`endif

endmodule

// ===== sim/pid_controller_anti_windup_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for pid_controller_anti_windup_core: directed and random samples
// are compared against a fixed-point PID predictor kept inside this file.
// Depends on pidaw_pkg and the core RTL only.
module pid_controller_anti_windup_core_tb;
  import pidaw_pkg::*;

  // Register indexes the block does not decode; writes to them must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  localparam longint DRIVE_MAX = (longint'(1) <<< 31) - 1;
  localparam longint DRIVE_MIN = -(longint'(1) <<< 31);
  localparam longint PROD_CAP  = longint'(1) <<< 48;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive;
    logic                      sampled;
  } pid_result_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]           wr_index = '0;
  logic [CFG_DATA_W-1:0]          wr_data = '0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic signed [SAMPLE_WIDTH-1:0] feedback = '0;
  logic [TIME_W-1:0]              now_ms = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic signed [DRIVE_W-1:0]      drive;
  logic                           sampled;

  // Controller settings as last written.
  logic signed [SETPOINT_W-1:0] setpoint_cfg = '0;
  logic signed [GAIN_W-1:0]     kp_cfg = '0;
  logic signed [GAIN_W-1:0]     ki_cfg = '0;
  logic signed [GAIN_W-1:0]     kd_cfg = '0;
  logic [TIME_W-1:0]            period_cfg = '0;
  logic [LIMIT_W-1:0]           windup_cfg = '0;

  // Controller state tracked by the predictor.
  logic [TIME_W-1:0]         last_time = '0;
  logic signed [ERR_W-1:0]   last_error = '0;
  logic signed [INTEG_W-1:0] integ_acc = '0;
  logic signed [DERIV_W-1:0] deriv_rate = '0;
  logic signed [DRIVE_W-1:0] held_out = '0;

  pid_result_t drive_expect_q[$];
  pid_result_t drive_head;
  int          mismatch_count = 0;
  logic        send_quiet = 1'b0;
  logic        recv_quiet = 1'b0;
  logic [TIME_W-1:0] clock_ms;

  pid_controller_anti_windup_core dut (
    .clk, .rst, .wr_en, .wr_index, .wr_data,
    .in_valid, .in_stall, .feedback, .now_ms,
    .out_valid, .out_stall, .drive, .sampled
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  function automatic logic signed [DRIVE_W-1:0] clip_drive(input longint v);
    if (v > DRIVE_MAX) return DRIVE_MAX[DRIVE_W-1:0];
    if (v < DRIVE_MIN) return DRIVE_MIN[DRIVE_W-1:0];
    return v[DRIVE_W-1:0];
  endfunction

  // Advances the controller by one sample and returns the result it must produce.
  function automatic pid_result_t advance_controller(input logic signed [SAMPLE_WIDTH-1:0] fb,
                                                      input logic [TIME_W-1:0] t);
    longint err, mag, prod, acc, lim, num, sum;
    logic [TIME_W-1:0] dt;
    pid_result_t res;
    err = longint'(setpoint_cfg) - longint'(fb);
    dt = t - last_time;
    res.sampled = 1'b0;
    if (dt >= period_cfg) begin
      // Integral gains error*dt and is clamped to the windup bound.
      mag = (err < 0) ? -err : err;
      prod = mag * longint'(dt);
      if (prod > PROD_CAP) prod = PROD_CAP;
      acc = longint'(integ_acc) + ((err < 0) ? -prod : prod);
      lim = longint'(windup_cfg);
      if (acc > lim) acc = lim;
      else if (acc < -lim) acc = -lim;
      integ_acc = acc[INTEG_W-1:0];
      // With no elapsed time the derivative keeps its old value.
      if (dt != '0) begin
        num = (err - longint'(last_error)) * (longint'(1) <<< FRAC_BITS);
        deriv_rate = clip_drive(num / longint'(dt));
      end
      last_time = t;
      last_error = err[ERR_W-1:0];
      sum = longint'(kp_cfg) * err + longint'(ki_cfg) * longint'(integ_acc)
          + ((longint'(kd_cfg) * longint'(deriv_rate)) >>> FRAC_BITS);
      held_out = clip_drive(sum >>> FRAC_BITS);
      res.sampled = 1'b1;
    end
    res.drive = held_out;
    return res;
  endfunction

  // Result checker and random output stall.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (drive_expect_q.size() == 0) begin
        $error("unexpected result: drive %0d sampled %0b", drive, sampled);
        mismatch_count++;
      end else begin
        drive_head = drive_expect_q.pop_front();
        if (drive !== drive_head.drive) begin
          $error("drive: expected %0d, got %0d", drive_head.drive, drive);
          mismatch_count++;
        end
        if (sampled !== drive_head.sampled) begin
          $error("sampled: expected %0b, got %0b", drive_head.sampled, sampled);
          mismatch_count++;
        end
      end
    end
    out_stall <= !recv_quiet && ($urandom_range(99) < 37);
  end

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= data;
  endtask

  // Writes every register (unused upper bits random) plus both undecoded indexes.
  task automatic program_regs(input logic signed [SETPOINT_W-1:0] sp,
                              input logic signed [GAIN_W-1:0] kp, ki, kd,
                              input logic [TIME_W-1:0] period, input logic [LIMIT_W-1:0] limit);
    logic [63:0] noise;
    noise = {$urandom, $urandom};
    put_reg(REG_SETPOINT, {noise[CFG_DATA_W-1:SETPOINT_W], sp});
    put_reg(REG_SPARE_A, noise[CFG_DATA_W-1:0]);
    put_reg(REG_GAIN_P, {noise[CFG_DATA_W+3:GAIN_W+4], kp});
    put_reg(REG_GAIN_I, {noise[CFG_DATA_W+9:GAIN_W+10], ki});
    put_reg(REG_GAIN_D, {noise[CFG_DATA_W+16:GAIN_W+17], kd});
    put_reg(REG_SAMPLE_PERIOD, {noise[CFG_DATA_W-1:TIME_W], period});
    put_reg(REG_WINDUP_LIMIT, limit);
    put_reg(REG_SPARE_B, ~noise[CFG_DATA_W-1:0]);
    @(posedge clk);
    wr_en <= 1'b0;
    setpoint_cfg = sp;
    kp_cfg = kp;
    ki_cfg = ki;
    kd_cfg = kd;
    period_cfg = period;
    windup_cfg = limit;
  endtask

  // Sends one sample transaction and records what it must produce.
  task automatic send_sample(input logic signed [SAMPLE_WIDTH-1:0] fb,
                             input logic [TIME_W-1:0] t);
    if (!send_quiet && $urandom_range(99) < 37) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    feedback <= fb;
    now_ms <= t;
    do @(posedge clk); while (in_stall);
    drive_expect_q.push_back(advance_controller(fb, t));
  endtask

  // Lets the block go idle so registers may be rewritten.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (drive_expect_q.size() != 0) @(posedge clk);
  endtask

  // All registers at reset value; zero elapsed time with a zero period.
  task automatic test_power_on_defaults();
    send_sample(16'sd0, 32'd0);
    send_sample(-16'sd32768, 32'd0);
    drain_results();
  endtask

  // Samples just below and at the period gate.
  task automatic test_sample_gate();
    program_regs(16'sd1000, 16'sd256, 16'sd128, 16'sd512, 32'd10, 47'd50000);
    send_sample(16'sd100, 32'd5);
    send_sample(16'sd100, 32'd10);
    send_sample(-16'sd32768, 32'd19);
    send_sample(16'sd32767, 32'd20);
    send_sample(16'sd12, 32'd29);
    drain_results();
  endtask

  // Huge elapsed time clamps the integral high; a wrapped timestamp clamps it low.
  task automatic test_time_wrap_and_clamp();
    send_sample(16'sd0, 32'hFFFF_FFF0);
    send_sample(16'sd32767, 32'h0000_0005);
    send_sample(16'sd32767, 32'h0000_0006);
    drain_results();
  endtask

  // Extreme setpoint, gains, period and windup bound; drive saturates high.
  task automatic test_extreme_gains();
    program_regs(-16'sd32768, 16'sd32767, -16'sd32768, -16'sd32768, 32'hFFFF_FFFF,
                 {LIMIT_W{1'b1}});
    send_sample(16'sd32767, 32'd4);
    send_sample(-16'sd1, 32'd3);
    send_sample(16'sd0, 32'd5);
    send_sample(-16'sd32768, 32'd2);
    drain_results();
  endtask

  // Drive saturates low; then a zero windup bound with large derivative swings.
  task automatic test_negative_saturation();
    program_regs(16'sd32767, 16'sd0, -16'sd32768, 16'sd0, 32'd0, {LIMIT_W{1'b1}});
    send_sample(-16'sd32768, 32'd1);
    send_sample(-16'sd32768, 32'd1);
    drain_results();
    program_regs(16'sd32767, -16'sd32768, 16'sd32767, 16'sd32767, 32'd0, '0);
    send_sample(-16'sd32768, 32'd2);
    send_sample(16'sd32767, 32'd3);
    send_sample(-16'sd32768, 32'd4);
    send_sample(16'sd0, 32'd4);
    drain_results();
  endtask

  function automatic logic signed [GAIN_W-1:0] pick_gain();
    if ($urandom_range(1) == 0) return GAIN_W'($urandom_range(1023)) - GAIN_W'(512);
    return GAIN_W'($urandom);
  endfunction

  // Random settings per phase; timestamps mostly advance around the period.
  task automatic test_random_sweep();
    logic [TIME_W-1:0]              period;
    logic [LIMIT_W-1:0]             limit;
    logic signed [SAMPLE_WIDTH-1:0] fb;
    int                             pick;
    for (int phase = 0; phase < 6; phase++) begin
      case ($urandom_range(9))
        0:       period = '0;
        7, 8:    period = TIME_W'($urandom_range(2000, 41));
        9:       period = $urandom;
        default: period = TIME_W'($urandom_range(40, 1));
      endcase
      case ($urandom_range(2))
        0:       limit = LIMIT_W'($urandom_range(100000));
        1:       limit = LIMIT_W'({$urandom, $urandom});
        default: limit = {LIMIT_W{1'b1}};
      endcase
      program_regs(SETPOINT_W'($urandom), pick_gain(), pick_gain(), pick_gain(), period, limit);
      send_quiet = (phase == 2);
      recv_quiet = (phase == 2);
      clock_ms = last_time;
      for (int n = 0; n < 105; n++) begin
        pick = $urandom_range(99);
        if (pick < 45) clock_ms = clock_ms + period_cfg + TIME_W'($urandom_range(8));
        else if (pick < 75) clock_ms = clock_ms + TIME_W'($urandom_range(period_cfg));
        else if (pick < 90) clock_ms = clock_ms + TIME_W'($urandom_range(3));
        else clock_ms = $urandom;
        if ($urandom_range(99) < 70) fb = SAMPLE_WIDTH'($urandom);
        else fb = setpoint_cfg + SAMPLE_WIDTH'($urandom_range(64)) - SAMPLE_WIDTH'(32);
        send_sample(fb, clock_ms);
      end
      drain_results();
    end
    send_quiet = 1'b0;
    recv_quiet = 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_power_on_defaults();
    test_sample_gate();
    test_time_wrap_and_clamp();
    test_extreme_gains();
    test_negative_saturation();
    test_random_sweep();
    // Settle time covering a full sample computation.
    repeat (64) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== pid_controller_anti_windup_core.f =====
rtl/pidaw_pkg.sv
rtl/pid_controller_anti_windup_core.sv
sim/pid_controller_anti_windup_core_tb.sv
